// File: sv/bqd_pkg.sv
// shared types and constants for the biquad filter
`timescale 1ns / 1ps

package bqd_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 24;
  localparam int CFG_IDX_BITS    = 3;

  // coefficient register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A1,
    ST_A2,
    ST_B1,
    ST_B2,
    ST_B0,
    ST_FIN
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_A1,
    OP_A2,
    OP_B1,
    OP_B2,
    OP_B0,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
    logic   commit;
  } dp_cmd_t;

endpackage

// File: sv/bqd_in_if.sv
// input sample channel
`timescale 1ns / 1ps

interface bqd_in_if #(
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// File: sv/bqd_out_if.sv
// filtered sample channel
`timescale 1ns / 1ps

interface bqd_out_if #(
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// File: sv/bqd_ctrl.sv
// sequencer for the shared multiplier and the output handshake
`timescale 1ns / 1ps

module bqd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bqd_pkg::dp_cmd_t cmd
);
  import bqd_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_A1;
      ST_A1:   state_nxt = ST_A2;
      ST_A2:   state_nxt = ST_B1;
      ST_B1:   state_nxt = ST_B2;
      ST_B2:   state_nxt = ST_B0;
      ST_B0:   state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_A1:   cmd.op = OP_A1;
      ST_A2:   cmd.op = OP_A2;
      ST_B1:   cmd.op = OP_B1;
      ST_B2:   cmd.op = OP_B2;
      ST_B0:   cmd.op = OP_B0;
      ST_FIN: begin
        cmd.op     = OP_FIN;
        cmd.commit = out_free;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/bqd_dp.sv
// coefficients, delay line, shared multiplier and accumulators
`timescale 1ns / 1ps

module bqd_dp #(
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqd_pkg::COEF_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bqd_pkg::dp_cmd_t                  cmd,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  input  logic                              cfg_we,
  input  logic [bqd_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [COEF_BITS-1:0]              cfg_data,
  output logic signed [SAMPLE_BITS-1:0]     sample_out,
  output logic                              clipped
);
  import bqd_pkg::*;

  localparam int DELAY_BITS = SAMPLE_BITS + 8;
  localparam int COEF_FRAC  = COEF_BITS - 2;
  localparam int PROD_BITS  = COEF_BITS + DELAY_BITS;
  localparam int ACC_BITS   = DELAY_BITS + 4;

  localparam logic signed [COEF_BITS-1:0] B0_RESET = {2'b01, {COEF_FRAC{1'b0}}};
  localparam logic signed [PROD_BITS:0]   HALF     =
    {{(PROD_BITS - COEF_FRAC + 2){1'b0}}, {(COEF_FRAC - 1){1'b0}}} |
    ((PROD_BITS + 1)'(1) << (COEF_FRAC - 1));
  localparam logic signed [ACC_BITS-1:0]  W_MAX =
    {{(ACC_BITS - DELAY_BITS + 1){1'b0}}, {(DELAY_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0]  W_MIN = ~W_MAX;
  localparam logic signed [ACC_BITS-1:0]  Y_MAX =
    {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0]  Y_MIN = ~Y_MAX;

  logic signed [COEF_BITS-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [DELAY_BITS-1:0]  d1_r, d2_r, w_r;
  logic signed [PROD_BITS-1:0]   p_r, p_nxt;
  logic signed [ACC_BITS-1:0]    accw_r, accy_r;
  logic                          whit_r;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;
  logic                          clipped_r;

  logic signed [COEF_BITS-1:0]   mul_c;
  logic signed [DELAY_BITS-1:0]  mul_w;
  logic signed [PROD_BITS:0]     p_half;
  logic signed [PROD_BITS:0]     p_shift;
  logic signed [ACC_BITS-1:0]    rnd;
  logic signed [DELAY_BITS-1:0]  w_sat;
  logic                          w_hit;
  logic signed [ACC_BITS-1:0]    y_sum;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_hit;

  // coefficient registers, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_B0:  b0_r <= cfg_data;
        REG_B1:  b1_r <= cfg_data;
        REG_B2:  b2_r <= cfg_data;
        REG_A1:  a1_r <= cfg_data;
        REG_A2:  a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_c = a1_r;
    mul_w = d1_r;
    unique case (cmd.op)
      OP_A1:   begin mul_c = a1_r; mul_w = d1_r; end
      OP_A2:   begin mul_c = a2_r; mul_w = d2_r; end
      OP_B1:   begin mul_c = b1_r; mul_w = d1_r; end
      OP_B2:   begin mul_c = b2_r; mul_w = d2_r; end
      OP_B0:   begin mul_c = b0_r; mul_w = w_r;  end
      default: begin mul_c = a1_r; mul_w = d1_r; end
    endcase
  end

  assign p_nxt = mul_c * mul_w;

  // round the previous product to the sample fraction, ties up
  assign p_half  = {p_r[PROD_BITS-1], p_r} + HALF;
  assign p_shift = p_half >>> COEF_FRAC;
  assign rnd     = p_shift[ACC_BITS-1:0];

  always_comb begin
    w_hit = 1'b0;
    w_sat = accw_r[DELAY_BITS-1:0];
    if (accw_r > W_MAX) begin
      w_hit = 1'b1;
      w_sat = W_MAX[DELAY_BITS-1:0];
    end else if (accw_r < W_MIN) begin
      w_hit = 1'b1;
      w_sat = W_MIN[DELAY_BITS-1:0];
    end
  end

  assign y_sum = accy_r + rnd;

  always_comb begin
    y_hit = 1'b0;
    y_sat = y_sum[SAMPLE_BITS-1:0];
    if (y_sum > Y_MAX) begin
      y_hit = 1'b1;
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (y_sum < Y_MIN) begin
      y_hit = 1'b1;
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (cmd.commit) begin
      d2_r <= d1_r;
      d1_r <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accw_r <= {{(ACC_BITS - SAMPLE_BITS){sample_in[SAMPLE_BITS-1]}}, sample_in};
    end
    case (cmd.op) inside
      OP_A1, OP_A2, OP_B1, OP_B2, OP_B0: p_r <= p_nxt;
      default: ;
    endcase
    case (cmd.op) inside
      OP_A2, OP_B1: accw_r <= accw_r - rnd;
      OP_B2: begin
        w_r    <= w_sat;
        whit_r <= w_hit;
        accy_r <= rnd;
      end
      OP_B0: accy_r <= y_sum;
      default: ;
    endcase
    if (cmd.commit) begin
      sample_out_r <= y_sat;
      clipped_r    <= whit_r | y_hit;
    end
  end

  assign sample_out = sample_out_r;
  assign clipped    = clipped_r;

endmodule

// File: sv/biquad_df2_filter.sv
// second-order iir section, direct form ii, one shared multiplier
//
//   port      dir  handshake         carries
//   in_ch     in   valid/ready       sample_in   signed Q1.23
//   out_ch    out  valid/ready       sample_out  signed Q1.23, clipped
//   cfg_*     in   cfg_we only       cfg_idx selects b0 b1 b2 a1 a2 (Q2.22)
//
// after a sample is accepted, its five products go one per cycle through the
// single multiplier, then a last step sums, saturates, shifts the delay line and
// loads the result into the output register. the next sample is taken the
// cycle after that. reset clears the delay line and loads b0 = 1.0. a full
// output register stalls the last step until the held transaction is taken.
`timescale 1ns / 1ps

module biquad_df2_filter #(
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqd_pkg::COEF_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bqd_in_if.sink                           in_ch,
  bqd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [bqd_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [COEF_BITS-1:0]             cfg_data
);
  import bqd_pkg::*;

  dp_cmd_t                       cmd;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  bqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  bqd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (in_ch.sample_in),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  assign out_ch.sample_out = sample_out;
  assign out_ch.clipped    = clipped;

endmodule

// File: test/tb.sv
// self-checking testbench for the direct form ii biquad section
`timescale 1ns / 1ps

module tb;
  import bqd_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int CB          = COEF_BITS_DEF;
  localparam int COEF_FRAC   = CB - 2;
  localparam int DELAY_BITS  = SB + 8;
  localparam int NUM_COEFS   = int'(REG_A2) + 1;
  localparam int IDLE_GAP    = 10;
  localparam int BLOCK_ITEMS = 80;
  localparam int BLOCKS      = 8;
  localparam int LIMIT       = 400000;

  typedef logic signed [SB-1:0] sample_t;
  typedef logic signed [CB-1:0] coef_t;
  typedef logic [CFG_IDX_BITS-1:0] idx_t;

  typedef struct packed {
    logic signed [SB-1:0] sample;
    logic                 clipped;
  } filt_result_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam coef_t   COEF_MAX   = {1'b0, {(CB-1){1'b1}}};
  localparam coef_t   COEF_MIN   = {1'b1, {(CB-1){1'b0}}};
  localparam coef_t   COEF_ONE   = coef_t'(1) <<< COEF_FRAC;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  idx_t  cfg_idx;
  coef_t cfg_data;

  bqd_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  bqd_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  biquad_df2_filter #(
    .SAMPLE_BITS(SB),
    .COEF_BITS  (CB)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // filter state as the predictor sees it
  longint coef_q [NUM_COEFS];
  longint w_prev1;
  longint w_prev2;

  filt_result_t expected_out [$];
  filt_result_t head;

  int in_idle_pct;
  int out_idle_pct;
  int errors;
  int results_seen;
  int clipped_seen;
  int settings_used;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint round_product(input longint c, input longint w);
    longint p;
    p = c * w + (longint'(1) <<< (COEF_FRAC - 1));
    return p >>> COEF_FRAC;
  endfunction

  function automatic longint clamp(input longint v, input int bits, inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // one sample through the section, shifting the delay line
  function automatic filt_result_t filter_step(input sample_t x);
    longint       w;
    longint       y;
    logic         hit;
    filt_result_t r;
    hit = 1'b0;
    w = longint'(x) - round_product(coef_q[REG_A1], w_prev1)
        - round_product(coef_q[REG_A2], w_prev2);
    w = clamp(w, DELAY_BITS, hit);
    y = round_product(coef_q[REG_B0], w) + round_product(coef_q[REG_B1], w_prev1)
        + round_product(coef_q[REG_B2], w_prev2);
    y = clamp(y, SB, hit);
    w_prev2 = w_prev1;
    w_prev1 = w;
    r.sample  = sample_t'(y);
    r.clipped = hit;
    return r;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(9))
      0:       s = SAMPLE_MAX;
      1:       s = SAMPLE_MIN;
      2, 3:    s = sample_t'(int'($urandom_range(4095)) - 2048);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic coef_t rand_coef();
    coef_t c;
    case ($urandom_range(9))
      0:             c = COEF_MAX;
      1:             c = COEF_MIN;
      2:             c = '0;
      3:             c = COEF_ONE;
      4, 5, 6:       c = coef_t'(int'($urandom_range(1 << 21)) - (1 << 20));
      default:       c = coef_t'($urandom);
    endcase
    return c;
  endfunction

  task automatic send_sample(input sample_t value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_out.push_back(filter_step(value));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_coef(input idx_t idx, input coef_t value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    // the register takes the value at this edge; reserved indexes do nothing
    if (idx <= REG_A2) coef_q[idx] = longint'(value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_filter(input coef_t b0, input coef_t b1, input coef_t b2,
                                input coef_t a1, input coef_t a2);
    wait_idle();
    write_coef(REG_B0, b0);
    write_coef(REG_B1, b1);
    write_coef(REG_B2, b2);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
    settings_used++;
  endtask

  // reset coefficients give a straight pass-through
  task automatic test_reset_passthrough();
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
  endtask

  task automatic test_unknown_index();
    wait_idle();
    for (int k = int'(REG_A2) + 1; k < (1 << CFG_IDX_BITS); k++) begin
      write_coef(idx_t'(k), coef_t'($urandom));
    end
    send_sample(rand_sample());
  endtask

  task automatic test_output_saturation();
    program_filter(COEF_MAX, '0, '0, '0, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    program_filter(COEF_MIN, '0, '0, '0, '0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
  endtask

  // feedback of -2.0 on both taps runs the delay word up to its positive rail,
  // then +2.0 throws it to the negative rail
  task automatic test_delay_saturation();
    program_filter(COEF_ONE, '0, '0, COEF_MIN, COEF_MIN);
    repeat (7) send_sample(SAMPLE_MAX);
    program_filter(COEF_ONE, '0, '0, COEF_MAX, COEF_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
  endtask

  task automatic test_coef_extremes();
    program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
  endtask

  task automatic test_random_filters();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 18;
          out_idle_pct = 68;
        end
        1: begin
          in_idle_pct  = 68;
          out_idle_pct = 18;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        program_filter(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
        repeat (BLOCK_ITEMS) send_sample(rand_sample());
      end
    end
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_out.size() == 0) begin
        $error("unexpected transaction: sample_out %0d clipped %0b",
               $signed(out_ch.sample_out), out_ch.clipped);
        errors++;
      end else begin
        head = expected_out.pop_front();
        if (out_ch.sample_out !== head.sample) begin
          $error("sample_out mismatch: expected %0d, actual %0d",
                 $signed(head.sample), $signed(out_ch.sample_out));
          errors++;
        end
        if (out_ch.clipped !== head.clipped) begin
          $error("clipped mismatch: expected %0b, actual %0b", head.clipped, out_ch.clipped);
          errors++;
        end
        results_seen++;
        if (head.clipped) clipped_seen++;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("biquad_df2_filter test failed");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    errors          = 0;
    results_seen    = 0;
    clipped_seen    = 0;
    settings_used   = 0;
    in_idle_pct     = 18;
    out_idle_pct    = 68;
    foreach (coef_q[i]) coef_q[i] = 0;
    coef_q[REG_B0] = longint'(COEF_ONE);
    w_prev1 = 0;
    w_prev2 = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_unknown_index();
    test_output_saturation();
    test_delay_saturation();
    test_coef_extremes();
    test_random_filters();
    wait_idle();

    $display("%0d filtered samples checked over %0d coefficient settings, %0d clipped",
             results_seen, settings_used, clipped_seen);
    $display("reserved register writes and three back-pressure patterns were exercised");
    if (errors == 0) begin
      $display("biquad_df2_filter test passed");
    end else begin
      $display("biquad_df2_filter test failed");
    end
    $finish;
  end

endmodule
